[rtl/core/mts_pkg.sv]
// Shared types and codes for the multi-slot tick timer table.
// No dependencies; imported by the top level, mts_ctrl and mts_out_reg.
package mts_pkg;

    // Request type codes on the input channel.
    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_ADD    = 2'd1,
        REQ_REMOVE = 2'd2
    } req_t;

    // Timer modes stored with each slot.
    typedef enum logic [1:0] {
        MODE_PERIODIC = 2'd0,
        MODE_ONESHOT  = 2'd1,
        MODE_LIMITED  = 2'd2
    } mode_t;

    // Result kind codes on the output channel.
    typedef enum logic [1:0] {
        KIND_FIRE   = 2'd0,
        KIND_ADD    = 2'd1,
        KIND_REMOVE = 2'd2
    } kind_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_CMD   = 2'd1,
        ST_SCAN  = 2'd2,
        ST_FLUSH = 2'd3
    } state_t;

    // One result as it travels from the sequencer to the output register.
    typedef struct packed {
        kind_t       kind;
        logic [3:0]  slot;
        logic        freed;
        logic        status;
        logic        last;
    } result_t;

endpackage

[rtl/core/multi_slot_tick_timer_table_core.sv]
// Top level of the multi-slot tick timer table.
// Depends on mts_pkg, mts_slot_ram, mts_ctrl and mts_out_reg.
//
//  Channel   Handshake              Payload
//  input     in_valid / in_ready    req_type, slot, mode, period, repeat_count
//  output    out_valid / out_ready  kind, out_slot, freed, status, last
//
// One request is in work at a time. An add or remove waits for output room.
// A tick reads one slot entry from the table RAM per cycle unless a firing
// finds the output register full, the write back of a slot overlapping the
// read of the next.
// Reset clears the tick count and all slot valid bits at once; no clearing pass.
module multi_slot_tick_timer_table_core import mts_pkg::*; #(
    parameter int SLOTS       = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [3:0]  slot,
    input  logic [1:0]  mode,
    input  logic [31:0] period,
    input  logic [15:0] repeat_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [3:0]  out_slot,
    output logic        freed,
    output logic        status,
    output logic        last
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int EW = 2 + 32 + 32 + COUNT_WIDTH;

    logic          space;
    logic          push;
    result_t       push_data;
    logic          rd_en;
    logic [SW-1:0] rd_addr;
    logic [EW-1:0] rd_data;
    logic          wr_en;
    logic [SW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    // Slot table: mode, period, deadline and remaining count per slot.
    mts_slot_ram #(
        .DEPTH (SLOTS),
        .AW    (SW),
        .DW    (EW)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Request sequencer and scan.
    mts_ctrl #(
        .SLOTS       (SLOTS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .slot         (slot),
        .mode         (mode),
        .period       (period),
        .repeat_count (repeat_count),
        .space        (space),
        .push         (push),
        .push_data    (push_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data)
    );

    // Result register toward the consumer.
    mts_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .out_slot  (out_slot),
        .freed     (freed),
        .status    (status),
        .last      (last)
    );

`ifndef NO_ASSERTIONS
    // A result is only pushed when the output register has room.
    a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> space)
        else $error("result pushed into a full output register");

    // Results come only from a request in work, never while a new one is taken.
    a_push_busy: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !in_ready)
        else $error("result pushed while idle");

    // The scan never reads the entry it is writing back.
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("table read and write hit the same entry");

    // Requests are taken one at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (req_type <= REQ_REMOVE)) |=> !in_ready)
        else $error("second request taken while one is in work");
`endif

endmodule

[rtl/core/mts_slot_ram.sv]
// Slot table storage: one write port and one read port with registered read data.
// Depends on nothing; sized by its parameters.
module mts_slot_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 82
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port; the data register holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/mts_out_reg.sv]
// Output register of the result channel; parts the sequencer from the consumer.
// Depends on mts_pkg for the result type.
module mts_out_reg import mts_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  result_t    push_data,
    output logic       space,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [3:0] out_slot,
    output logic       freed,
    output logic       status,
    output logic       last
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // The register can load when it is empty or is being emptied this cycle.
    assign space = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= push_data;
        end
    end

    assign out_valid = valid_reg;
    assign kind      = data_reg.kind;
    assign out_slot  = data_reg.slot;
    assign freed     = data_reg.freed;
    assign status    = data_reg.status;
    assign last      = data_reg.last;

endmodule

[rtl/core/mts_ctrl.sv]
// Sequencer of the timer table: request decode, add and remove, tick scan.
// Depends on mts_pkg; drives the slot RAM and the output register.
module mts_ctrl import mts_pkg::*; #(
    parameter int SLOTS       = 16,
    parameter int COUNT_WIDTH = 16,
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int EW = 2 + 32 + 32 + COUNT_WIDTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    req_type,
    input  logic [3:0]    slot,
    input  logic [1:0]    mode,
    input  logic [31:0]   period,
    input  logic [15:0]   repeat_count,
    input  logic          space,
    output logic          push,
    output result_t       push_data,
    output logic          rd_en,
    output logic [SW-1:0] rd_addr,
    input  logic [EW-1:0] rd_data,
    output logic          wr_en,
    output logic [SW-1:0] wr_addr,
    output logic [EW-1:0] wr_data
);

    state_t                 state_reg, state_next;
    logic [1:0]             req_reg;
    logic [3:0]             slot_reg;
    logic [1:0]             mode_reg;
    logic [31:0]            period_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [31:0]            now_reg, now_next;
    logic [SW-1:0]          idx_reg, idx_next;
    logic [SLOTS-1:0]       valid_reg, valid_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [SW-1:0]          pend_slot_reg, pend_slot_next;
    logic                   pend_freed_reg, pend_freed_next;

    logic                   accept;
    logic [SW-1:0]          slot_idx;
    logic                   slot_oor;
    logic                   add_err;
    logic                   rem_err;
    logic [COUNT_WIDTH-1:0] count_fix;
    logic [1:0]             ent_mode;
    logic [31:0]            ent_period;
    logic [31:0]            ent_deadline;
    logic [COUNT_WIDTH-1:0] ent_rem;
    logic [COUNT_WIDTH-1:0] rem_dec;
    logic                   fire;
    logic                   fire_freed;
    logic                   is_last;
    logic                   scan_go;

    assign accept = in_valid && in_ready;

    // Decode of the latched add or remove request.
    assign slot_idx  = SW'(slot_reg);
    assign slot_oor  = 32'(slot_reg) >= 32'(SLOTS);
    assign add_err   = slot_oor || (mode_reg > MODE_LIMITED) || valid_reg[slot_idx];
    assign rem_err   = slot_oor || !valid_reg[slot_idx];
    assign count_fix = (count_reg == '0) ? COUNT_WIDTH'(1) : count_reg;

    // Fields of the entry read from the table.
    assign ent_mode     = rd_data[EW-1 -: 2];
    assign ent_period   = rd_data[EW-3 -: 32];
    assign ent_deadline = rd_data[COUNT_WIDTH+31 -: 32];
    assign ent_rem      = rd_data[COUNT_WIDTH-1:0];

    // Firing decision for the slot under scan.
    assign rem_dec = ent_rem - COUNT_WIDTH'(1);
    assign fire    = valid_reg[idx_reg] && (ent_deadline <= now_reg);
    always_comb
    begin
        case (mode_t'(ent_mode))
            MODE_ONESHOT: fire_freed = 1'b1;
            MODE_LIMITED: fire_freed = (rem_dec == '0);
            default:      fire_freed = 1'b0;
        endcase
    end

    // A new firing pushes out the one held before; that push needs room.
    assign is_last = (idx_reg == SW'(SLOTS - 1));
    assign scan_go = !(fire && pend_valid_reg && !space);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (req_t'(req_type))
                        REQ_TICK:   state_next = ST_SCAN;
                        REQ_ADD:    state_next = ST_CMD;
                        REQ_REMOVE: state_next = ST_CMD;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CMD:
            begin
                if (space)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (scan_go && is_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg || space)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath updates of each state.
    always_comb
    begin
        in_ready        = 1'b0;
        push            = 1'b0;
        push_data       = '{KIND_FIRE, 4'd0, 1'b0, 1'b0, 1'b0};
        rd_en           = 1'b0;
        rd_addr         = idx_reg + SW'(1);
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = {ent_mode, ent_period, now_reg + ent_period, rem_dec};
        now_next        = now_reg;
        idx_next        = idx_reg;
        valid_next      = valid_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_freed_next = pend_freed_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                // A tick advances the count and starts the read of slot zero.
                if (in_valid && (req_type == REQ_TICK))
                begin
                    now_next = now_reg + 32'd1;
                    idx_next = '0;
                    rd_en    = 1'b1;
                    rd_addr  = '0;
                end
            end
            ST_CMD:
            begin
                if (space)
                begin
                    case (req_t'(req_reg))
                        REQ_ADD:
                        begin
                            push      = 1'b1;
                            push_data = '{KIND_ADD, slot_reg, 1'b0, add_err, 1'b1};
                            if (!add_err)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = slot_idx;
                                wr_data = {mode_reg, period_reg, now_reg + period_reg,
                                           count_fix};
                                valid_next[slot_idx] = 1'b1;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            push      = 1'b1;
                            push_data = '{KIND_REMOVE, slot_reg, !rem_err, rem_err, 1'b1};
                            if (!rem_err)
                            begin
                                valid_next[slot_idx] = 1'b0;
                            end
                        end
                        default: push = 1'b0;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_go)
                begin
                    if (fire)
                    begin
                        push      = pend_valid_reg;
                        push_data = '{KIND_FIRE, 4'(pend_slot_reg), pend_freed_reg,
                                      1'b0, 1'b0};
                        pend_valid_next = 1'b1;
                        pend_slot_next  = idx_reg;
                        pend_freed_next = fire_freed;
                        if (fire_freed)
                        begin
                            valid_next[idx_reg] = 1'b0;
                        end
                        else
                        begin
                            wr_en = 1'b1;
                        end
                    end
                    // The next slot's read overlaps this slot's write back.
                    if (!is_last)
                    begin
                        idx_next = idx_reg + SW'(1);
                        rd_en    = 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (pend_valid_reg && space)
                begin
                    push            = 1'b1;
                    push_data       = '{KIND_FIRE, 4'(pend_slot_reg), pend_freed_reg,
                                        1'b0, 1'b1};
                    pend_valid_next = 1'b0;
                end
            end
            default: in_ready = 1'b0;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            now_reg        <= '0;
            idx_reg        <= '0;
            valid_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            idx_reg        <= idx_next;
            valid_reg      <= valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Request and held-result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg    <= req_type;
            slot_reg   <= slot;
            mode_reg   <= mode;
            period_reg <= period;
            count_reg  <= COUNT_WIDTH'(repeat_count);
        end
        pend_slot_reg  <= pend_slot_next;
        pend_freed_reg <= pend_freed_next;
    end

endmodule

[verif/tb_multi_slot_tick_timer_table_core.sv]
`timescale 1ns / 100ps
// Self-checking testbench for multi_slot_tick_timer_table_core: directed table then random traffic.
// Depends on mts_pkg and the block's RTL; predicts untyped responses with its own slot table model.
module tb_multi_slot_tick_timer_table_core;
    import mts_pkg::*;

    localparam int SLOT_COUNT = 16;
    localparam int RANDOM_REQUESTS = 480;
    localparam int DRAIN_CYCLES = 2 * (SLOT_COUNT + 2);
    localparam int MAX_WAIT = 5;

    // Codes that the package enums leave out but the ports can carry.
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // One row of the directed stimulus; the t_ fields hold a typed-in response.
    typedef struct {
        logic [1:0]  req;
        logic [3:0]  slot;
        logic [1:0]  mode;
        logic [31:0] period;
        logic [15:0] count;
        bit          typed;
        kind_t       t_kind;
        bit          t_freed;
        bit          t_status;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type = REQ_TICK;
    logic [3:0]  slot = '0;
    logic [1:0]  mode = MODE_PERIODIC;
    logic [31:0] period = '0;
    logic [15:0] repeat_count = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [3:0]  out_slot;
    logic        freed;
    logic        status;
    logic        last;

    // Shadow copy of the timer table.
    logic [31:0] tick_count = '0;
    logic        armed [SLOT_COUNT] = '{default: 1'b0};
    logic [1:0]  arm_mode [SLOT_COUNT];
    logic [31:0] arm_period [SLOT_COUNT];
    logic [31:0] arm_deadline [SLOT_COUNT];
    logic [15:0] arm_left [SLOT_COUNT];

    result_t     step_results [$];
    result_t     timer_responses [$];
    bit          failed = 1'b0;
    bit          sender_quiet = 1'b0;
    bit          receiver_quiet = 1'b0;

    multi_slot_tick_timer_table_core #(
        .SLOTS       (SLOT_COUNT),
        .COUNT_WIDTH (16)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .slot         (slot),
        .mode         (mode),
        .period       (period),
        .repeat_count (repeat_count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .out_slot     (out_slot),
        .freed        (freed),
        .status       (status),
        .last         (last)
    );

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Applies one request to the shadow table and lists the responses it causes.
    task automatic timer_table_step(input logic [1:0] req, input logic [3:0] idx,
                                    input logic [1:0] md, input logic [31:0] per,
                                    input logic [15:0] cnt);
        result_t r;
        step_results.delete();
        case (req)
            REQ_TICK:
            begin
                tick_count = tick_count + 32'd1;
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (armed[i] && arm_deadline[i] <= tick_count)
                    begin
                        r.freed = 1'b0;
                        if (arm_mode[i] == MODE_ONESHOT)
                            r.freed = 1'b1;
                        else if (arm_mode[i] == MODE_LIMITED)
                        begin
                            arm_left[i] = arm_left[i] - 16'd1;
                            if (arm_left[i] == 16'd0)
                                r.freed = 1'b1;
                        end
                        if (r.freed)
                            armed[i] = 1'b0;
                        else
                            arm_deadline[i] = tick_count + arm_period[i];
                        r.kind = KIND_FIRE;
                        r.slot = 4'(i);
                        r.status = 1'b0;
                        r.last = 1'b0;
                        step_results.push_back(r);
                    end
                end
                if (step_results.size() > 0)
                    step_results[step_results.size() - 1].last = 1'b1;
            end
            REQ_ADD:
            begin
                r.kind = KIND_ADD;
                r.slot = idx;
                r.freed = 1'b0;
                r.last = 1'b1;
                r.status = (md > MODE_LIMITED) || armed[idx];
                if (!r.status)
                begin
                    armed[idx] = 1'b1;
                    arm_mode[idx] = md;
                    arm_period[idx] = per;
                    arm_deadline[idx] = tick_count + per;
                    arm_left[idx] = (cnt == 16'd0) ? 16'd1 : cnt;
                end
                step_results.push_back(r);
            end
            REQ_REMOVE:
            begin
                r.kind = KIND_REMOVE;
                r.slot = idx;
                r.last = 1'b1;
                r.status = !armed[idx];
                r.freed = armed[idx];
                armed[idx] = 1'b0;
                step_results.push_back(r);
            end
            default:
            begin
                // Unused request type: no response, no change.
            end
        endcase
    endtask

    // Presents one request, waits for it to be taken and files its responses.
    task automatic send_request(input stim_row_t row);
        int      gap;
        result_t r;
        gap = sender_quiet ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= row.req;
        slot <= row.slot;
        mode <= row.mode;
        period <= row.period;
        repeat_count <= row.count;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        timer_table_step(row.req, row.slot, row.mode, row.period, row.count);
        if (row.typed)
        begin
            r.kind = row.t_kind;
            r.slot = row.slot;
            r.freed = row.t_freed;
            r.status = row.t_status;
            r.last = 1'b1;
            timer_responses.push_back(r);
        end
        else
        begin
            foreach (step_results[k])
                timer_responses.push_back(step_results[k]);
        end
    endtask

    // Draws one random request; most periods are short so that slots really fire.
    function automatic stim_row_t random_request();
        stim_row_t row;
        int        pick;
        pick = $urandom_range(0, 99);
        row.typed = 1'b0;
        row.t_kind = KIND_FIRE;
        row.t_freed = 1'b0;
        row.t_status = 1'b0;
        row.slot = 4'($urandom);
        row.mode = 2'($urandom);
        row.period = $urandom;
        row.count = 16'($urandom);
        if (pick < 42)
            row.req = REQ_TICK;
        else if (pick < 72)
        begin
            row.req = REQ_ADD;
            row.mode = ($urandom_range(0, 19) == 0) ? MODE_UNUSED
                                                   : 2'($urandom_range(0, 2));
            pick = $urandom_range(0, 99);
            if (pick < 70)
                row.period = $urandom_range(0, 8);
            else if (pick < 85)
                row.period = $urandom_range(0, 40);
            if ($urandom_range(0, 9) < 7)
                row.count = 16'($urandom_range(0, 4));
        end
        else if (pick < 96)
            row.req = REQ_REMOVE;
        else
            row.req = REQ_UNUSED;
        return row;
    endfunction

    // Response checker: every accepted response against the oldest one predicted.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (timer_responses.size() == 0)
            begin
                $display("%0t: unexpected response kind=%0d slot=%0d freed=%0b status=%0b last=%0b",
                         $time, kind, out_slot, freed, status, last);
                failed = 1'b1;
            end
            else
            begin
                want = timer_responses.pop_front();
                if (kind !== want.kind)
                begin
                    $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind);
                    failed = 1'b1;
                end
                if (out_slot !== want.slot)
                begin
                    $display("%0t: out_slot expected %0d actual %0d", $time, want.slot, out_slot);
                    failed = 1'b1;
                end
                if (freed !== want.freed)
                begin
                    $display("%0t: freed expected %0b actual %0b", $time, want.freed, freed);
                    failed = 1'b1;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0b actual %0b", $time, want.status, status);
                    failed = 1'b1;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last expected %0b actual %0b", $time, want.last, last);
                    failed = 1'b1;
                end
            end
        end
    end

    // Response side: random stalls per response, with stall-free stretches.
    initial
    begin
        int stall;
        int taken;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            if (taken % 64 == 0)
                receiver_quiet = ($urandom_range(0, 3) == 0);
            stall = receiver_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            taken++;
        end
    end

    // Request side: reset, directed table, random traffic, drain and verdict.
    initial
    begin
        stim_row_t directed [25];
        stim_row_t row;
        int        sent;
        directed = '{
            // Tick right after reset: nothing armed, nothing due.
            '{REQ_TICK, 4'd0, MODE_PERIODIC, 32'd0, 16'd0, 0, KIND_FIRE, 0, 0},
            // Remove of an empty slot, with the unused fields all ones.
            '{REQ_REMOVE, 4'd3, MODE_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 1, KIND_REMOVE, 0, 1},
            '{REQ_ADD, 4'd0, MODE_PERIODIC, 32'd0, 16'd0, 1, KIND_ADD, 0, 0},
            // Add to a busy slot.
            '{REQ_ADD, 4'd0, MODE_ONESHOT, 32'd5, 16'd5, 1, KIND_ADD, 0, 1},
            // Largest period wraps the deadline behind the tick count.
            '{REQ_ADD, 4'd15, MODE_ONESHOT, 32'hFFFF_FFFF, 16'd0, 1, KIND_ADD, 0, 0},
            // Limited mode with a zero count runs once.
            '{REQ_ADD, 4'd1, MODE_LIMITED, 32'd1, 16'd0, 1, KIND_ADD, 0, 0},
            '{REQ_ADD, 4'd2, MODE_LIMITED, 32'd0, 16'hFFFF, 1, KIND_ADD, 0, 0},
            // Mode outside the three defined ones is rejected.
            '{REQ_ADD, 4'd4, MODE_UNUSED, 32'd3, 16'd3, 1, KIND_ADD, 0, 1},
            // Unused request type gives nothing back.
            '{REQ_UNUSED, 4'd15, MODE_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 0, KIND_FIRE, 0, 0},
            '{REQ_TICK, 4'd15, MODE_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 0, KIND_FIRE, 0, 0},
            '{REQ_TICK, 4'd0, MODE_PERIODIC, 32'd0, 16'd0, 0, KIND_FIRE, 0, 0},
            '{REQ_ADD, 4'd5, MODE_ONESHOT, 32'd2, 16'hFFFF, 1, KIND_ADD, 0, 0},
            '{REQ_TICK, 4'd0, MODE_PERIODIC, 32'd0, 16'd0, 0, KIND_FIRE, 0, 0},
            '{REQ_TICK, 4'd0, MODE_PERIODIC, 32'd0, 16'd0, 0, KIND_FIRE, 0, 0},
            '{REQ_REMOVE, 4'd2, MODE_ONESHOT, 32'd0, 16'd0, 1, KIND_REMOVE, 1, 0},
            '{REQ_REMOVE, 4'd5, MODE_PERIODIC, 32'd0, 16'd0, 0, KIND_FIRE, 0, 0},
            '{REQ_ADD, 4'd6, MODE_PERIODIC, 32'h8000_0000, 16'h8000, 1, KIND_ADD, 0, 0},
            '{REQ_TICK, 4'd0, MODE_PERIODIC, 32'd0, 16'd0, 0, KIND_FIRE, 0, 0},
            '{REQ_REMOVE, 4'd0, MODE_PERIODIC, 32'd0, 16'd0, 1, KIND_REMOVE, 1, 0},
            '{REQ_REMOVE, 4'd6, MODE_PERIODIC, 32'd0, 16'd0, 1, KIND_REMOVE, 1, 0},
            // One-shot and single-run limited slots are already gone.
            '{REQ_REMOVE, 4'd15, MODE_PERIODIC, 32'd0, 16'd0, 1, KIND_REMOVE, 0, 1},
            '{REQ_REMOVE, 4'd1, MODE_PERIODIC, 32'd0, 16'd0, 1, KIND_REMOVE, 0, 1},
            '{REQ_ADD, 4'd7, MODE_LIMITED, 32'd3, 16'd2, 1, KIND_ADD, 0, 0},
            '{REQ_TICK, 4'd0, MODE_PERIODIC, 32'd0, 16'd0, 0, KIND_FIRE, 0, 0},
            '{REQ_TICK, 4'd0, MODE_PERIODIC, 32'd0, 16'd0, 0, KIND_FIRE, 0, 0}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_request(directed[i]);

        // Hold off until the table has answered everything so far.
        in_valid <= 1'b0;
        @(posedge clk);
        while (timer_responses.size() != 0) @(posedge clk);

        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            if (sent % 64 == 0)
                sender_quiet = ($urandom_range(0, 3) == 0);
            if (sent == RANDOM_REQUESTS / 2)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (timer_responses.size() != 0) @(posedge clk);
            end
            row = random_request();
            send_request(row);
            if (row.req != REQ_UNUSED)
                sent++;
        end
        in_valid <= 1'b0;

        while (timer_responses.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed)
            $display("multi_slot_tick_timer_table_core regression: pass");
        else
            $display("multi_slot_tick_timer_table_core regression: fail");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #5_000_000;
        $display("multi_slot_tick_timer_table_core regression: fail");
        $finish;
    end

endmodule
